### hdl/u8enc_pkg.sv
// Package for the bounded UTF-32 to UTF-8 encoder.
// It holds the payload structs, the job descriptor and the shared constants.
// No dependencies; every other file in hdl/ imports it.
`default_nettype none

package u8enc_pkg;

  // Width of the running byte count, which saturates at all ones.
  localparam int COUNT_BITS = 18;
  // Width that holds both the capacity register and the count.
  localparam int CAP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  // One more bit, so that the end position of a sequence is exact.
  localparam int CMP_W      = CAP_W + 1;
  // Width of the reported total length.
  localparam int TOT_W      = 18;
  // Width that holds both the count and the saturated total.
  localparam int SAT_W      = (COUNT_BITS > TOT_W) ? COUNT_BITS : TOT_W;
  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOT_W-1:0]      TOTAL_MAX = 18'h3FFFF;

  // Code point limits and lead byte marks.
  localparam logic [31:0] CP_ONE_LIMIT   = 32'h0000_0080;
  localparam logic [31:0] CP_TWO_LIMIT   = 32'h0000_0800;
  localparam logic [31:0] CP_FOUR_START  = 32'h0001_0000;
  localparam logic [31:0] CP_MAX         = 32'h0010_FFFF;
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [7:0]  LEAD_TWO       = 8'hC0;
  localparam logic [7:0]  LEAD_THREE     = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR      = 8'hF0;
  localparam logic [7:0]  CONT_MARK      = 8'h80;
  localparam logic [5:0]  CONT_MASK      = 6'h3F;

  // One input beat.
  typedef struct packed {
    logic [31:0] code_point;
    logic        last_in;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic             write_enable;
    logic [15:0]      write_index;
    logic [7:0]       byte_value;
    logic             length_valid;
    logic [TOT_W-1:0] total_length;
    logic             run_last;
  } out_item_t;

  // Everything the back end needs to emit the beats of one item.
  typedef struct packed {
    logic [2:0]       wr_count;   // byte writes, 0 to 4
    logic [15:0]      pos;        // index of the first byte write
    logic [3:0][7:0]  bytes;      // bytes in write order, entry 0 first
    logic             last;       // a length beat follows the writes
    logic             term_we;    // the length beat also writes a terminator
    logic [15:0]      term_idx;
    logic [TOT_W-1:0] total;
  } job_t;

endpackage

`default_nettype wire

### hdl/u8enc_front.sv
// Front end: holds the capacity register and the string state, encodes each
// code point and turns it into a job descriptor. Depends on u8enc_pkg.
`default_nettype none

module u8enc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 src_valid,
  output logic                      src_ready,
  input  wire u8enc_pkg::in_item_t  src_item,
  input  wire logic                 job_ready,
  output logic                      job_push,
  output u8enc_pkg::job_t           job
);
  import u8enc_pkg::*;

  logic [15:0]           dest_capacity;
  logic [COUNT_BITS-1:0] byte_count;
  logic                  dest_full;

  logic [20:0]           cp;
  logic [2:0]            n;
  logic [3:0][7:0]       enc;
  logic [CAP_W-1:0]      cap_ext;
  logic [CAP_W-1:0]      cmax_ext;
  logic [CAP_W-1:0]      cap;
  logic [CAP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      end_pos;
  logic                  no_room;
  logic                  active;
  logic                  full_set;
  logic [2:0]            wr_count;
  logic [3:0][7:0]       out_bytes;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic                  dest_full_next;
  logic [CAP_W-1:0]      cnt_ext;
  logic [SAT_W-1:0]      cnt_sat;
  logic                  accept;

  assign src_ready = job_ready;
  assign accept    = src_valid && src_ready;

  // Replace out of range values, then encode.
  always_comb begin
    cp  = (src_item.code_point > CP_MAX) ? CP_REPLACEMENT : src_item.code_point[20:0];
    enc = '0;
    if ({11'd0, cp} < CP_ONE_LIMIT) begin
      n      = 3'd1;
      enc[0] = {1'b0, cp[6:0]};
    end else if ({11'd0, cp} < CP_TWO_LIMIT) begin
      n      = 3'd2;
      enc[0] = LEAD_TWO | {3'd0, cp[10:6]};
      enc[1] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
    end else if ({11'd0, cp} >= CP_FOUR_START) begin
      n      = 3'd4;
      enc[0] = LEAD_FOUR | {5'd0, cp[20:18]};
      enc[1] = CONT_MARK | {2'd0, cp[17:12] & CONT_MASK};
      enc[2] = CONT_MARK | {2'd0, cp[11:6] & CONT_MASK};
      enc[3] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
    end else begin
      n      = 3'd3;
      enc[0] = LEAD_THREE | {4'd0, cp[15:12]};
      enc[1] = CONT_MARK | {2'd0, cp[11:6] & CONT_MASK};
      enc[2] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
    end
  end

  // Usable capacity is bounded by what the count can reach.
  assign cap_ext  = CAP_W'(dest_capacity);
  assign cmax_ext = CAP_W'(COUNT_MAX);
  assign cap      = (cap_ext < cmax_ext) ? cap_ext : cmax_ext;
  assign pos_ext  = CAP_W'(byte_count);
  assign end_pos  = CMP_W'(byte_count) + CMP_W'(n);
  assign no_room  = end_pos >= CMP_W'(cap);
  assign active   = (cap != '0) && !dest_full;

  // Decide the writes. A sequence without room becomes a single terminator.
  always_comb begin
    wr_count  = 3'd0;
    out_bytes = enc;
    full_set  = 1'b0;
    if (active) begin
      if (no_room) begin
        wr_count  = 3'd1;
        out_bytes = '0;
        full_set  = 1'b1;
      end else begin
        wr_count = n;
      end
    end
  end

  // Saturating count and the state after this item.
  assign sum             = {1'b0, byte_count} + (COUNT_BITS+1)'(n);
  assign byte_count_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
  assign dest_full_next  = dest_full || full_set;
  assign cnt_ext         = CAP_W'(byte_count_next);
  assign cnt_sat         = SAT_W'(byte_count_next);

  // Job descriptor for the back end.
  always_comb begin
    job.wr_count = wr_count;
    job.pos      = pos_ext[15:0];
    job.bytes    = out_bytes;
    job.last     = src_item.last_in;
    job.term_we  = (cap != '0) && !dest_full_next;
    job.term_idx = cnt_ext[15:0];
    job.total    = (cnt_sat > SAT_W'(TOTAL_MAX)) ? TOTAL_MAX : cnt_sat[TOT_W-1:0];
  end

  // Items that cause no beat update the state only.
  assign job_push = accept && ((wr_count != 3'd0) || src_item.last_in);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_capacity <= '0;
    end else if (cfg_we) begin
      dest_capacity <= cfg_data;
    end
  end

  // String state, cleared after each last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      dest_full  <= 1'b0;
    end else if (accept) begin
      if (src_item.last_in) begin
        byte_count <= '0;
        dest_full  <= 1'b0;
      end else begin
        byte_count <= byte_count_next;
        dest_full  <= dest_full_next;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/u8enc_queue.sv
// Short job queue that decouples the front end from the back end.
// Depends on u8enc_pkg for the job type and depth.
`default_nettype none

module u8enc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire u8enc_pkg::job_t  push_job,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output u8enc_pkg::job_t       pop_job
);
  import u8enc_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/u8enc_back.sv
// Back end: takes jobs from the queue and emits one result beat per cycle,
// while dst_ready allows, through an output register. Depends on u8enc_pkg.
`default_nettype none

module u8enc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  input  wire u8enc_pkg::job_t  job_in,
  output logic                  job_pop,
  output logic                  dst_valid,
  input  wire logic             dst_ready,
  output u8enc_pkg::out_item_t  dst_item
);
  import u8enc_pkg::*;

  job_t      cur;
  logic      cur_valid;
  logic [2:0] idx;
  logic [2:0] beats;
  logic      final_beat;
  logic      adv;
  out_item_t beat;

  assign adv        = !dst_valid || dst_ready;
  assign beats      = cur.wr_count + {2'd0, cur.last};
  assign final_beat = idx == (beats - 3'd1);
  assign job_pop    = job_valid && (!cur_valid || (adv && final_beat));

  // Build the beat for the current position in the job.
  always_comb begin
    beat = '0;
    if (idx < cur.wr_count) begin
      beat.write_enable = 1'b1;
      beat.write_index  = cur.pos + {14'd0, idx[1:0]};
      beat.byte_value   = cur.bytes[idx[1:0]];
    end else begin
      beat.write_enable = cur.term_we;
      beat.write_index  = cur.term_we ? cur.term_idx : 16'd0;
      beat.length_valid = 1'b1;
      beat.total_length = cur.total;
    end
    beat.run_last = final_beat;
  end

  // Current job and beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (job_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (adv && cur_valid) begin
      if (final_beat) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job_in;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (adv) begin
      dst_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cur_valid) begin
      dst_item <= beat;
    end
  end

endmodule

`default_nettype wire

### hdl/utf32_to_utf8_bounded_encoder.sv
// Top level of the bounded UTF-32 to UTF-8 encoder: front end, job queue
// and back end. Depends on u8enc_pkg, u8enc_front, u8enc_queue, u8enc_back.
//
//   channel  signals                          beat
//   src      src_valid src_ready src_item      one code point (in_item_t)
//   dst      dst_valid dst_ready dst_item      one write or length result
//   cfg      cfg_we cfg_data                   dest_capacity, no wait
//
// The front end accepts one code point per cycle while the queue has room.
// The back end sends one result beat per cycle while dst_ready allows; each
// item causes 0 to 5 results, one byte per dst beat. With the back end idle,
// an item passes the queue, the current job register and the output register
// before its first result is presented. Reset clears capacity and string
// state. A stalled dst fills the queue, and src_ready then drops.
`default_nettype none

module utf32_to_utf8_bounded_encoder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire u8enc_pkg::in_item_t   src_item,
  output logic                       dst_valid,
  input  wire logic                  dst_ready,
  output u8enc_pkg::out_item_t       dst_item
);
  import u8enc_pkg::*;

  job_t front_job;
  job_t back_job;
  logic job_push;
  logic job_ready;
  logic job_valid;
  logic job_pop;

  u8enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .job_ready (job_ready),
    .job_push  (job_push),
    .job       (front_job)
  );

  u8enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (front_job),
    .push_ready (job_ready),
    .pop        (job_pop),
    .pop_valid  (job_valid),
    .pop_job    (back_job)
  );

  u8enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (back_job),
    .job_pop   (job_pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for utf32_to_utf8_bounded_encoder.
// Depends on hdl/u8enc_pkg.sv and the encoder RTL; an internal predictor of
// the byte stream and the length result checks every result beat.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8enc_pkg::*;

  localparam int LEN_LIMIT     = 262143;  // saturation value of the byte count
  localparam int SETTLE_CYCLES = 12;      // quiet time after the last expected beat
  localparam int RAND_ITEMS    = 325;

  // One row of the directed stimulus.
  typedef struct {
    bit          set_cap;
    logic [15:0] cap;
    logic [31:0] cp;
    bit          last;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        src_valid;
  logic        src_ready;
  in_item_t    src_item;
  logic        dst_valid;
  logic        dst_ready;
  out_item_t   dst_item;

  // Predictor state: capacity mirror, running length and closed flag.
  int          cap_mirror;
  int          len_count;
  bit          dest_closed;
  out_item_t   utf8_beats_q[$];

  // Typed expectation that travels with the beat currently on src.
  bit          cur_typed;
  out_item_t   cur_want;

  bit          tx_steady;
  bit          rx_steady;
  int          errors;
  int          accepted;
  int          checked;
  int          strings_done;
  stim_row_t   dir_rows[$];

  utf32_to_utf8_bounded_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h", checked, name, got,
                                want));
    end
  endtask

  // Encodes one code point and queues the result beats it should cause.
  task automatic encode_point(input logic [31:0] cp_in, input bit last);
    logic [31:0] c;
    logic [7:0]  seq [4];
    out_item_t   beats [5];
    int          n;
    int          k;
    int          pos;
    bit          fill;
    k = 0;
    pos = len_count;
    c = (cp_in > 32'h0010_FFFF) ? 32'h0000_FFFD : cp_in;
    for (int i = 0; i < 5; i++) beats[i] = '0;
    if (c < 32'h80) begin
      n = 1;
      seq[0] = c[7:0];
    end else if (c < 32'h800) begin
      n = 2;
      seq[0] = 8'hC0 | {3'b000, c[10:6]};
      seq[1] = 8'h80 | {2'b00, c[5:0]};
    end else if (c >= 32'h1_0000) begin
      n = 4;
      seq[0] = 8'hF0 | {5'b00000, c[20:18]};
      seq[1] = 8'h80 | {2'b00, c[17:12]};
      seq[2] = 8'h80 | {2'b00, c[11:6]};
      seq[3] = 8'h80 | {2'b00, c[5:0]};
    end else begin
      n = 3;
      seq[0] = 8'hE0 | {4'b0000, c[15:12]};
      seq[1] = 8'h80 | {2'b00, c[11:6]};
      seq[2] = 8'h80 | {2'b00, c[5:0]};
    end

    // Byte writes, or a lone terminator where the sequence does not fit.
    if (cap_mirror != 0 && !dest_closed) begin
      if (n == 1) begin
        fill = (pos + 1 >= cap_mirror);
        beats[k].write_enable = 1'b1;
        beats[k].write_index  = pos[15:0];
        beats[k].byte_value   = fill ? 8'h00 : seq[0];
        k++;
        if (fill) dest_closed = 1'b1;
      end else if (pos + n >= cap_mirror) begin
        beats[k].write_enable = 1'b1;
        beats[k].write_index  = pos[15:0];
        k++;
        dest_closed = 1'b1;
      end else begin
        for (int j = 0; j < n; j++) begin
          beats[k].write_enable = 1'b1;
          beats[k].write_index  = 16'(pos + j);
          beats[k].byte_value   = seq[j];
          k++;
        end
      end
    end

    len_count = (len_count + n > LEN_LIMIT) ? LEN_LIMIT : len_count + n;

    // The last code point closes the string with a length beat.
    if (last) begin
      beats[k].length_valid = 1'b1;
      beats[k].total_length = len_count[17:0];
      if (cap_mirror != 0 && !dest_closed) begin
        beats[k].write_enable = 1'b1;
        beats[k].write_index  = len_count[15:0];
      end
      k++;
      len_count = 0;
      dest_closed = 1'b0;
    end

    if (k > 0) beats[k-1].run_last = 1'b1;
    for (int i = 0; i < k; i++) utf8_beats_q.push_back(beats[i]);
  endtask

  // Predicts on every accepted code point and checks every result beat.
  always @(posedge clk) begin : monitor
    out_item_t want;
    int        q_mark;
    if (!rst) begin
      if (src_valid && src_ready) begin
        q_mark = utf8_beats_q.size();
        encode_point(src_item.code_point, src_item.last_in);
        if (cur_typed) begin
          while (utf8_beats_q.size() > q_mark) utf8_beats_q.delete(utf8_beats_q.size() - 1);
          utf8_beats_q.push_back(cur_want);
        end
        accepted++;
      end
      if (dst_valid && dst_ready) begin
        if (utf8_beats_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: idx %0d byte 0x%02h",
                                    dst_item.write_index, dst_item.byte_value));
        end else begin
          want = utf8_beats_q.pop_front();
          check_field("write_enable", 32'(dst_item.write_enable), 32'(want.write_enable));
          check_field("write_index", 32'(dst_item.write_index), 32'(want.write_index));
          check_field("byte_value", 32'(dst_item.byte_value), 32'(want.byte_value));
          check_field("length_valid", 32'(dst_item.length_valid), 32'(want.length_valid));
          check_field("total_length", 32'(dst_item.total_length), 32'(want.total_length));
          check_field("run_last", 32'(dst_item.run_last), 32'(want.run_last));
          checked++;
        end
      end
    end
  end

  // Receiver stalls: mostly short, a few long, none while rx_steady is set.
  initial begin : rx_side
    int hold;
    int sel;
    logic lvl;
    hold = 0;
    lvl = 1'b1;
    dst_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_steady) begin
        lvl = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          lvl = 1'b1;
          hold = $urandom_range(0, 15);
        end else if (sel < 95) begin
          lvl = 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          lvl = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
      dst_ready <= lvl;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (tx_steady || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [31:0] pick_code_point();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return $urandom_range(0, 32'h7F);
      4, 5:       return $urandom_range(32'h80, 32'h7FF);
      6, 7:       return $urandom_range(32'h800, 32'hFFFF);
      8:          return $urandom_range(32'hD800, 32'hDFFF);
      9, 10:      return $urandom_range(32'h1_0000, 32'h10_FFFF);
      11:         return $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
      12, 13:     return $urandom;
      default: begin
        // Values right at the encoding boundaries.
        case ($urandom_range(0, 9))
          0:       return 32'h0;
          1:       return 32'h7F;
          2:       return 32'h80;
          3:       return 32'h7FF;
          4:       return 32'h800;
          5:       return 32'hFFFF;
          6:       return 32'h1_0000;
          7:       return 32'h10_FFFF;
          8:       return 32'h11_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'($urandom_range(3, 5));
      4:       return 16'hFFFF;
      5:       return 16'($urandom_range(6, 16));
      default: return 16'($urandom_range(8, 48));
    endcase
  endfunction

  function automatic out_item_t one_beat(bit we, int idx, int val, bit lv, int tot);
    out_item_t r;
    r.write_enable = we;
    r.write_index  = idx[15:0];
    r.byte_value   = val[7:0];
    r.length_valid = lv;
    r.total_length = tot[17:0];
    r.run_last     = 1'b1;
    return r;
  endfunction

  task automatic add_row(input bit set_cap, input int cap, input logic [31:0] cp,
                         input bit last, input bit typed, input out_item_t want);
    stim_row_t r;
    r.set_cap = set_cap;
    r.cap     = cap[15:0];
    r.cp      = cp;
    r.last    = last;
    r.typed   = typed;
    r.want    = want;
    dir_rows.push_back(r);
  endtask

  // Presents one code point after an idle gap and waits for its beat.
  task automatic send_beat(input in_item_t it, input int gap, input bit typed,
                           input out_item_t want);
    repeat (gap) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_item  <= it;
    cur_typed <= typed;
    cur_want  <= want;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
  endtask

  // Holds the sender off until every pending beat has come and the block is quiet.
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (utf8_beats_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_data   <= value;
    cap_mirror = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hard limit on the run time.
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    int       str_len;
    int       rand_sent;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    src_valid  = 1'b0;
    src_item   = '0;
    cur_typed  = 1'b0;
    cur_want   = '0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    cap_mirror = 0;
    len_count  = 0;
    dest_closed = 1'b0;
    errors     = 0;
    accepted   = 0;
    checked    = 0;
    strings_done = 0;
    rand_sent  = 0;

    // Measure only after reset: every length class and the replacement path.
    add_row(0, 0, 32'h0000_0000, 0, 0, '0);
    add_row(0, 0, 32'h0000_007F, 0, 0, '0);
    add_row(0, 0, 32'h0000_0080, 0, 0, '0);
    add_row(0, 0, 32'h0000_07FF, 0, 0, '0);
    add_row(0, 0, 32'h0000_0800, 0, 0, '0);
    add_row(0, 0, 32'h0000_D800, 0, 0, '0);
    add_row(0, 0, 32'h0000_FFFF, 0, 0, '0);
    add_row(0, 0, 32'h0001_0000, 0, 0, '0);
    add_row(0, 0, 32'h0010_FFFF, 0, 0, '0);
    add_row(0, 0, 32'h0011_0000, 0, 0, '0);
    add_row(0, 0, 32'hFFFF_FFFF, 1, 1, one_beat(0, 0, 0, 1, 29));
    // Largest capacity: full sequences and a terminator.
    add_row(1, 65535, 32'h0000_0024, 0, 0, '0);
    add_row(0, 0, 32'h0000_07FF, 0, 0, '0);
    add_row(0, 0, 32'h0000_FFFF, 0, 0, '0);
    add_row(0, 0, 32'h0010_FFFF, 0, 0, '0);
    add_row(0, 0, 32'h8000_0000, 1, 0, '0);
    // Capacity one: a single byte that reaches capacity, then only counting.
    add_row(1, 1, 32'h0000_0041, 0, 1, one_beat(1, 0, 0, 0, 0));
    add_row(0, 0, 32'h0000_20AC, 1, 1, one_beat(0, 0, 0, 1, 4));
    add_row(0, 0, 32'h0000_0100, 1, 0, '0);
    // Capacity four: multi-byte sequences that leave no room.
    add_row(1, 4, 32'h0001_0000, 1, 0, '0);
    add_row(0, 0, 32'h0000_0041, 0, 0, '0);
    add_row(0, 0, 32'h0000_0042, 0, 0, '0);
    add_row(0, 0, 32'h0000_0800, 1, 0, '0);
    // Capacity two: terminator after one byte, and a byte that fills it.
    add_row(1, 2, 32'h0000_0041, 1, 0, '0);
    add_row(0, 0, 32'h0000_007E, 0, 0, '0);
    add_row(0, 0, 32'h0000_007F, 1, 0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cap) begin
        drain();
        write_capacity(dir_rows[i].cap);
      end
      it.code_point = dir_rows[i].cp;
      it.last_in    = dir_rows[i].last;
      send_beat(it, pick_gap(), dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].last) strings_done++;
    end

    // Random strings over random capacities, with steady stretches mixed in.
    while (rand_sent < RAND_ITEMS) begin
      if (strings_done % 8 == 0 || $urandom_range(0, 2) == 0) begin
        drain();
        if ($urandom_range(0, 1) == 1) write_capacity(pick_capacity());
      end
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int j = 0; j < str_len; j++) begin
        it.code_point = pick_code_point();
        it.last_in    = (j == str_len - 1);
        send_beat(it, pick_gap(), 1'b0, '0);
        rand_sent++;
      end
      strings_done++;
    end

    drain();
    if (utf8_beats_q.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", utf8_beats_q.size()));
    end
    $display("Run covered %0d code points in %0d strings, %0d result beats checked,",
             accepted, strings_done, checked);
    $display("capacities from 0 to 65535 with stalls on both sides; %0d errors.", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
